FILE: rtl/swmk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmk_pkg
// Shared types, widths and constants for the swerve module kinematics block.
// ----------------------------------------------------------------------------
package swmk_pkg;

   localparam int MODULE_COUNT = 4;
   localparam int MOD_IW       = 2;
   localparam int FIELD_W      = 16;
   localparam int VEC_W        = 17;
   localparam int CORDIC_W     = 28;
   localparam int ANGLE_W      = 27;
   localparam int ZWRAP_W      = 25;
   localparam int HEADING_W    = 15;
   localparam int MAG_W        = 19;
   localparam int STEER_W      = 15;
   localparam int SPEED_W      = 18;
   localparam int ATAN_W       = 22;
   localparam int ATAN_IW      = 5;
   localparam int PROD_W       = 43;
   localparam int GAIN_W       = 16;

   localparam int IN_TDATA_W   = 48;
   localparam int OUT_TDATA_W  = 136;
   localparam int SPEED_BASE   = MODULE_COUNT * STEER_W;

   localparam logic [15:0] FULL_TURN     = 16'd23040;
   localparam logic [15:0] QUARTER_TURN  = 16'd5760;
   localparam logic [15:0] STEER_OFFSET  = 16'd17280;
   localparam logic [15:0] STEER_OFF_REV = 16'd28800;
   localparam logic [15:0] TWO_TURNS     = 16'd46080;

   localparam logic signed [VEC_W-1:0]   INV_SQRT2_Q16 = 17'sd46341;
   localparam logic [GAIN_W-1:0]         INV_GAIN_Q16  = 16'd39797;
   localparam logic signed [ANGLE_W-1:0] DEG180_Q16    = 27'sd11796480;
   localparam logic signed [ANGLE_W-1:0] DEG360_Q16    = 27'sd23592960;
   localparam logic signed [19:0]        SPEED_MAX     = 20'sd131071;

   // bit k set: rotation term is subtracted for module k+1
   localparam logic [MODULE_COUNT-1:0] ROT_X_NEG = 4'b1100;
   localparam logic [MODULE_COUNT-1:0] ROT_Y_NEG = 4'b0110;

   localparam logic [1:0] MOD_LAST = 2'd3;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
   } swmk_vec_type;

   typedef struct packed {
      logic                 done;
      logic [HEADING_W-1:0] heading;
      logic [MAG_W-1:0]     magnitude;
   } swmk_polar_type;

   // atan(2^-i) in degrees, Q16
   function automatic logic [ATAN_W-1:0] atan_deg(input logic [ATAN_IW-1:0] idx);
      logic [ATAN_W-1:0] v;
      case (idx)
         5'd0:    v = 22'd2949120;
         5'd1:    v = 22'd1740967;
         5'd2:    v = 22'd919879;
         5'd3:    v = 22'd466945;
         5'd4:    v = 22'd234379;
         5'd5:    v = 22'd117304;
         5'd6:    v = 22'd58666;
         5'd7:    v = 22'd29335;
         5'd8:    v = 22'd14668;
         5'd9:    v = 22'd7334;
         5'd10:   v = 22'd3667;
         5'd11:   v = 22'd1833;
         5'd12:   v = 22'd917;
         5'd13:   v = 22'd458;
         5'd14:   v = 22'd229;
         5'd15:   v = 22'd115;
         5'd16:   v = 22'd57;
         5'd17:   v = 22'd29;
         5'd18:   v = 22'd14;
         5'd19:   v = 22'd7;
         5'd20:   v = 22'd4;
         5'd21:   v = 22'd2;
         5'd22:   v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/swmk_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmk_cordic
// Vectoring CORDIC: one micro-rotation per cycle, then angle wrap, rounding
// and gain correction, giving heading in 1/64 degree and vector magnitude.
// ----------------------------------------------------------------------------
module swmk_cordic #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  swmk_pkg::swmk_vec_type   vec,
   output swmk_pkg::swmk_polar_type polar
);
   import swmk_pkg::*;

   localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS - 1);

   typedef enum logic [4:0] {
      C_IDLE  = 5'b00001,
      C_ITER  = 5'b00010,
      C_WRAP  = 5'b00100,
      C_SCALE = 5'b01000,
      C_OUT   = 5'b10000
   } cordic_state_type;

   cordic_state_type state_ff, state_in;
   logic signed [CORDIC_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ANGLE_W-1:0]  z_ff, z_in;
   logic [ZWRAP_W-1:0]         zw_ff, zw_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [IW-1:0]              step_ff, step_in;
   logic                       zero_ff, zero_in;
   logic [HEADING_W-1:0]       heading_ff, heading_in;
   logic [MAG_W-1:0]           mag_ff, mag_in;

   logic signed [CORDIC_W-1:0] xs, ys, sh_x, sh_y;
   logic signed [ANGLE_W-1:0]  atan_e;
   logic [CORDIC_W-2:0]        cx_pos;
   logic [ZWRAP_W:0]           zsum;
   logic [15:0]                zr;
   logic [PROD_W-1:0]          msum;

   always_comb begin
      xs     = {{(CORDIC_W-VEC_W-8){vec.x[VEC_W-1]}}, vec.x, 8'b0};
      ys     = {{(CORDIC_W-VEC_W-8){vec.y[VEC_W-1]}}, vec.y, 8'b0};
      sh_x   = cx_ff >>> step_ff;
      sh_y   = cy_ff >>> step_ff;
      atan_e = $signed({{(ANGLE_W-ATAN_W){1'b0}}, atan_deg(ATAN_IW'(step_ff))});
      cx_pos = cx_ff[CORDIC_W-1] ? '0 : cx_ff[CORDIC_W-2:0];
      zsum   = {1'b0, zw_ff} + 26'd512;
      zr     = zsum[ZWRAP_W:10];
      msum   = prod_ff + (PROD_W'(1) << 23);

      state_in   = state_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      z_in       = z_ff;
      zw_in      = zw_ff;
      prod_in    = prod_ff;
      step_in    = step_ff;
      zero_in    = zero_ff;
      heading_in = heading_ff;
      mag_in     = mag_ff;

      case (state_ff)
         C_IDLE: begin
            if (start) begin
               zero_in = (vec.x == '0) && (vec.y == '0);
               step_in = '0;
               // move the vector into the right half plane first
               if (vec.x[VEC_W-1]) begin
                  cx_in = -xs;
                  cy_in = -ys;
                  z_in  = DEG180_Q16;
               end else begin
                  cx_in = xs;
                  cy_in = ys;
                  z_in  = '0;
               end
               state_in = C_ITER;
            end
         end
         C_ITER: begin
            if (cy_ff > 0) begin
               cx_in = cx_ff + sh_y;
               cy_in = cy_ff - sh_x;
               z_in  = z_ff + atan_e;
            end else begin
               cx_in = cx_ff - sh_y;
               cy_in = cy_ff + sh_x;
               z_in  = z_ff - atan_e;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = C_WRAP;
            end
         end
         C_WRAP: begin
            if (z_ff < 0) begin
               zw_in = ZWRAP_W'(z_ff + DEG360_Q16);
            end else if (z_ff >= DEG360_Q16) begin
               zw_in = ZWRAP_W'(z_ff - DEG360_Q16);
            end else begin
               zw_in = ZWRAP_W'(z_ff);
            end
            prod_in  = {{(PROD_W-CORDIC_W+1){1'b0}}, cx_pos} *
                       {{(PROD_W-GAIN_W){1'b0}}, INV_GAIN_Q16};
            state_in = C_SCALE;
         end
         C_SCALE: begin
            if (zero_ff || (zr >= FULL_TURN)) begin
               heading_in = '0;
            end else begin
               heading_in = zr[HEADING_W-1:0];
            end
            mag_in   = zero_ff ? '0 : msum[PROD_W-1:24];
            state_in = C_OUT;
         end
         C_OUT: begin
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      z_ff       <= z_in;
      zw_ff      <= zw_in;
      prod_ff    <= prod_in;
      step_ff    <= step_in;
      zero_ff    <= zero_in;
      heading_ff <= heading_in;
      mag_ff     <= mag_in;
   end

   assign polar.done      = (state_ff == C_OUT);
   assign polar.heading   = heading_ff;
   assign polar.magnitude = mag_ff;

endmodule

FILE: rtl/swerve_module_kinematics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swerve_module_kinematics
// Swerve drive inverse kinematics: chassis command in, steering angle and
// wheel speed for four modules out.
// ----------------------------------------------------------------------------
// One chassis command (vel_x, vel_y, rotate_rate) yields one result item with
// four steering targets (1/64 degree, 0..23039) and four saturated wheel
// speeds. The four modules go one after another through a single vectoring
// CORDIC unit, one micro-rotation per cycle, so req_tready stays low once an
// item is accepted until the result of all four modules has been written to
// the output register. A finished result waits in the output register, so the
// next command is taken while the previous result is still unread; if that
// result is still unread when the next one is ready, the block waits until it
// is taken. Each module keeps a reverse flag that toggles when its heading
// jumps by more than 90 degrees; while set, the target turns by 180 degrees
// and the speed flips.
// csr_wr_data selects wheels whose speed is negated (reset value 4'b0010).
module swerve_module_kinematics #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // vel_x, vel_y, rotate_rate
   input  logic [swmk_pkg::IN_TDATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // steer_angle_1..4, wheel_speed_1..4, zero pad
   output logic [swmk_pkg::OUT_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [swmk_pkg::MODULE_COUNT-1:0]   csr_wr_data
);
   import swmk_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_PREP   = 7'b0000010,
      S_LAUNCH = 7'b0000100,
      S_WAIT   = 7'b0001000,
      S_FLAG   = 7'b0010000,
      S_STORE  = 7'b0100000,
      S_HOLD   = 7'b1000000
   } seq_state_type;

   seq_state_type state_ff, state_in;
   logic signed [FIELD_W-1:0] vx_ff, vx_in, vy_ff, vy_in, rot_ff, rot_in, rr_ff, rr_in;
   logic [MOD_IW-1:0]         k_ff, k_in;
   logic [MODULE_COUNT-1:0]   mask_ff, mask_in;
   logic [MODULE_COUNT-1:0]   reverse_ff, reverse_in;
   logic [HEADING_W-1:0]      last_ff [MODULE_COUNT];
   logic [HEADING_W-1:0]      last_in [MODULE_COUNT];
   logic [STEER_W-1:0]        steer_w_ff [MODULE_COUNT];
   logic [STEER_W-1:0]        steer_w_in [MODULE_COUNT];
   logic [SPEED_W-1:0]        speed_w_ff [MODULE_COUNT];
   logic [SPEED_W-1:0]        speed_w_in [MODULE_COUNT];
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [OUT_TDATA_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                      start;
   swmk_vec_type              vec;
   swmk_polar_type            polar;

   logic signed [32:0]        rr_prod, rr_sum;
   logic signed [VEC_W:0]     vx_e, vy_e, rr_e, mx, my, nx;
   logic [HEADING_W-1:0]      d, alt, ang_dist, last_k;
   logic                      toggle;
   logic [15:0]               steer_base;
   logic [STEER_W-1:0]        steer_mod;
   logic signed [19:0]        mag_s, spd;
   logic [SPEED_W-1:0]        spd_sat;
   logic [OUT_TDATA_W-1:0]    pack_data;

   swmk_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (start),
      .vec   (vec),
      .polar (polar)
   );

   always_comb begin
      // r = round(rotate * 46341 / 2^16)
      rr_prod = rot_ff * INV_SQRT2_Q16;
      rr_sum  = rr_prod + 33'sd32768;

      vx_e = {{(VEC_W+1-FIELD_W){vx_ff[FIELD_W-1]}}, vx_ff};
      vy_e = {{(VEC_W+1-FIELD_W){vy_ff[FIELD_W-1]}}, vy_ff};
      rr_e = {{(VEC_W+1-FIELD_W){rr_ff[FIELD_W-1]}}, rr_ff};
      mx   = ROT_X_NEG[k_ff] ? (vx_e - rr_e) : (vx_e + rr_e);
      my   = ROT_Y_NEG[k_ff] ? (vy_e - rr_e) : (vy_e + rr_e);
      nx   = -mx;
      vec.x = nx[VEC_W-1:0];
      vec.y = my[VEC_W-1:0];

      // shortest angular distance to the previous heading
      last_k   = last_ff[k_ff];
      d        = (polar.heading >= last_k) ? (polar.heading - last_k)
                                           : (last_k - polar.heading);
      alt      = HEADING_W'(FULL_TURN) - d;
      ang_dist = (d < alt) ? d : alt;
      toggle   = ({1'b0, ang_dist} > QUARTER_TURN);

      steer_base = {1'b0, last_k} + (reverse_ff[k_ff] ? STEER_OFF_REV : STEER_OFFSET);
      if (steer_base >= TWO_TURNS) begin
         steer_mod = STEER_W'(steer_base - TWO_TURNS);
      end else if (steer_base >= FULL_TURN) begin
         steer_mod = STEER_W'(steer_base - FULL_TURN);
      end else begin
         steer_mod = steer_base[STEER_W-1:0];
      end

      mag_s = $signed({1'b0, polar.magnitude});
      spd   = (reverse_ff[k_ff] ^ mask_ff[k_ff]) ? -mag_s : mag_s;
      if (spd > SPEED_MAX) begin
         spd_sat = SPEED_MAX[SPEED_W-1:0];
      end else if (spd < -SPEED_MAX) begin
         spd_sat = SPEED_W'(-SPEED_MAX);
      end else begin
         spd_sat = spd[SPEED_W-1:0];
      end

      pack_data = '0;
      for (int m = 0; m < MODULE_COUNT; m++) begin
         pack_data[m*STEER_W +: STEER_W]              = steer_w_ff[m];
         pack_data[SPEED_BASE + m*SPEED_W +: SPEED_W] = speed_w_ff[m];
      end
   end

   always_comb begin
      state_in     = state_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      rot_in       = rot_ff;
      rr_in        = rr_ff;
      k_in         = k_ff;
      mask_in      = mask_ff;
      reverse_in   = reverse_ff;
      last_in      = last_ff;
      steer_w_in   = steer_w_ff;
      speed_w_in   = speed_w_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      start        = 1'b0;

      if (csr_wr_en) begin
         mask_in = csr_wr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               vx_in    = req_tdata[15:0];
               vy_in    = req_tdata[31:16];
               rot_in   = req_tdata[47:32];
               k_in     = '0;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            rr_in    = rr_sum[31:16];
            state_in = S_LAUNCH;
         end
         S_LAUNCH: begin
            start    = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (polar.done) begin
               state_in = S_FLAG;
            end
         end
         S_FLAG: begin
            reverse_in[k_ff] = reverse_ff[k_ff] ^ toggle;
            last_in[k_ff]    = polar.heading;
            state_in         = S_STORE;
         end
         S_STORE: begin
            steer_w_in[k_ff] = steer_mod;
            speed_w_in[k_ff] = spd_sat;
            if (k_ff == MOD_LAST) begin
               state_in = S_HOLD;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_LAUNCH;
            end
         end
         S_HOLD: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = pack_data;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mask_ff      <= 4'b0010;
         reverse_ff   <= '0;
         last_ff      <= '{default: '0};
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         reverse_ff   <= reverse_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
      end
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      rot_ff      <= rot_in;
      rr_ff       <= rr_in;
      steer_w_ff  <= steer_w_in;
      speed_w_ff  <= speed_w_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/swmk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmk_checker
// Port-level checks for the swerve module kinematics block, bound to the top.
// ----------------------------------------------------------------------------
module swmk_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [swmk_pkg::OUT_TDATA_W-1:0]   rsp_tdata
);
   import swmk_pkg::*;

   // output is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled item holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // block is busy in the cycle after taking an item
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready high right after accept");

   // steering targets stay within one turn
   a_steer_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[14:0] < 15'd23040) && (rsp_tdata[29:15] < 15'd23040) &&
                     (rsp_tdata[44:30] < 15'd23040) && (rsp_tdata[59:45] < 15'd23040))
      else $error("steering target out of range");

   // speeds saturate symmetrically and pad bits stay clear
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[77:60] != 18'h20000) && (rsp_tdata[95:78] != 18'h20000) &&
                     (rsp_tdata[113:96] != 18'h20000) && (rsp_tdata[131:114] != 18'h20000) &&
                     (rsp_tdata[135:132] == 4'b0))
      else $error("wheel speed out of range or pad bits set");

endmodule

bind swerve_module_kinematics swmk_checker u_swmk_checker (.*);
